>>> hw/rtl/swip_pkg.sv
`timescale 1ns / 1ps
// Package for the Simpson weighted inner product: types, constants and arithmetic helpers.
package swip_pkg;

  // Field widths of the streams and the configuration port.
  localparam int SAMPLE_W   = 24;
  localparam int NOISE_W    = 32;
  localparam int FREQ_W     = 24;
  localparam int IN_TDATA_W = 4 * SAMPLE_W + NOISE_W + FREQ_W;
  localparam int RESULT_W   = 64;
  localparam int COUNT_W    = 17;
  localparam int SPACING_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_MODE     = 2'd2;

  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 17'd3;
  localparam logic [COUNT_W-1:0] MAX_SAMPLES        = 17'd65536;

  // Divider: 66-bit dividend, 32-bit divisor, two quotient bits per cycle.
  localparam int DIV_W      = 66;
  localparam int DIV_CYCLES = DIV_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);
  localparam logic [31:0] DIV_THREE = 32'd3;

  // Right shifts applied after the two-part products.
  localparam int SHIFT_LOG  = 8;
  localparam int SHIFT_SIMP = 24;
  localparam int SHIFT_TAIL = 23;

  localparam logic [63:0] MAG_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAG_NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RE1,
    S_RE2,
    S_DLOAD,
    S_DIV,
    S_DDONE,
    S_MLO,
    S_MHI,
    S_MSAT,
    S_WEIGHT,
    S_ACC,
    S_SPREP,
    S_TPREP,
    S_FSUM,
    S_EMIT
  } state_t;

  // Which quantity the shared units are working on.
  typedef enum logic [1:0] {
    JOB_TERM,
    JOB_SIMP,
    JOB_TAIL
  } job_t;

  typedef struct packed {
    logic [31:0]      rem;
    logic [DIV_W-1:0] quo;
  } div_state_t;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  function automatic div_state_t div_step(input div_state_t s, input logic [31:0] den);
    logic [32:0] r1;
    div_state_t  o;
    r1 = {s.rem, s.quo[DIV_W-1]};
    if (r1 >= {1'b0, den}) begin
      o.rem = 32'(r1 - {1'b0, den});
      o.quo = {s.quo[DIV_W-2:0], 1'b1};
    end else begin
      o.rem = r1[31:0];
      o.quo = {s.quo[DIV_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // Clamp a magnitude to what a signed 64-bit value of the given sign can hold.
  function automatic logic [63:0] sat_mag(input logic [95:0] v, input logic neg);
    logic [63:0] lim;
    lim = neg ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
    if (v > {32'd0, lim}) begin
      return lim;
    end
    return v[63:0];
  endfunction

  function automatic logic [63:0] with_sign(input logic neg, input logic [63:0] mag);
    return neg ? 64'(-mag) : mag;
  endfunction

  // Saturating two's complement add.
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      return a[63] ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
    end
    return s;
  endfunction

endpackage

>>> hw/rtl/simpson_weighted_inner_product.sv
`timescale 1ns / 1ps
// Top level of the noise-weighted inner product by composite Simpson quadrature.
//
// Each input item on the in_ stream carries one grid sample: two complex values, a noise
// power and a frequency. The block forms Re(h1 * conj(h2)) / P, scales it by the frequency
// in log mode, and adds it with Simpson weights 1,4,2,...,4,1 (plus a trapezoid over the
// last interval when the length is even). After the configured number of items it sends
// one result item on the out_ stream: the saturated integral in tdata and the too-short
// flag in tuser. Items that do not end an integral produce no result.
// An item runs through the iterative divider, which retires two quotient bits per cycle
// over a 66-bit dividend. The item that ends an integral goes on to a final scaling,
// which reuses the same multiplier and divider (the divide by three). With a sample
// count of zero every item is answered right away with a zero result.
// The block takes one item at a time; in_tready is high only while the sequencer is idle.
// A finished result sits in the output register, so the next item is accepted while it
// waits; if a second result is ready before the first is taken, the sequencer holds.
// Reset (rst_n low, synchronous) restores the register defaults (sample count 3, spacing 0,
// linear mode), clears both sums and the sample position and drops out_tvalid.
// Configuration writes land on the clock edge where cfg_we is high, and are expected
// only while no item is being worked on.
module simpson_weighted_inner_product (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata from bit 0 up: first_re, first_im, second_re, second_im, noise_power, frequency
  input  logic [swip_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata: integral
  output logic [swip_pkg::RESULT_W-1:0]      out_tdata,
  // out_tuser: too_short
  output logic                               out_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [swip_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swip_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import swip_pkg::*;

  // Control state.
  state_t                 state_r, state_nxt;
  job_t                   job_r, job_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]     sample_count_r, sample_count_nxt;
  logic [SPACING_W-1:0]   spacing_r, spacing_nxt;
  logic                   log_mode_r, log_mode_nxt;
  logic [COUNT_W-1:0]     sample_index_r, sample_index_nxt;
  logic [63:0]            simpson_r, simpson_nxt;
  logic [63:0]            tail_r, tail_nxt;

  // Datapath registers.
  logic [SAMPLE_W-1:0]    first_re_r, first_re_nxt;
  logic [SAMPLE_W-1:0]    first_im_r, first_im_nxt;
  logic [SAMPLE_W-1:0]    second_re_r, second_re_nxt;
  logic [SAMPLE_W-1:0]    second_im_r, second_im_nxt;
  logic [NOISE_W-1:0]     noise_power_r, noise_power_nxt;
  logic [FREQ_W-1:0]      frequency_r, frequency_nxt;
  logic [48:0]            re_r, re_nxt;
  logic [95:0]            prod_r, prod_nxt;
  logic [63:0]            mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [31:0]            div_rem_r, div_rem_nxt;
  logic [DIV_W-1:0]       div_quo_r, div_quo_nxt;
  logic [31:0]            div_den_r, div_den_nxt;
  logic [63:0]            s_r, s_nxt;
  logic [63:0]            t_r, t_nxt;
  logic [63:0]            wterm_r, wterm_nxt;
  logic [63:0]            tterm_r, tterm_nxt;
  logic [63:0]            res_r, res_nxt;
  logic                   too_short_r, too_short_nxt;
  logic [63:0]            out_integral_r, out_integral_nxt;
  logic                   out_too_short_r, out_too_short_nxt;

  // Combinational helpers.
  logic                   in_accept;
  logic                   out_load;
  logic [COUNT_W-1:0]     len;
  logic [COUNT_W-1:0]     end_idx;
  logic                   sw_en;
  logic [1:0]             sw_shift;
  logic                   tw_en;
  logic                   last_item;
  logic [31:0]            mult_m;
  logic signed [32:0]     mul_a;
  logic signed [32:0]     mul_b;
  logic signed [65:0]     mul_p;
  div_state_t             div_s0, div_s1, div_s2;
  logic [95:0]            shifted;
  logic [63:0]            msat_mag;
  logic [63:0]            quo_sat;
  logic [48:0]            re_abs;
  logic [65:0]            wsh;
  logic [63:0]            wsat;
  logic [63:0]            simpson_abs;
  logic [63:0]            tail_abs;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_integral_r;
  assign out_tuser  = out_too_short_r;

  // Effective length and the quadrature weights of the current position.
  assign len       = (sample_count_r > MAX_SAMPLES) ? MAX_SAMPLES : sample_count_r;
  assign end_idx   = len[0] ? (len - 17'd1) : (len - 17'd2);
  assign sw_en     = (end_idx != '0) && (sample_index_r <= end_idx);
  assign sw_shift  = ((sample_index_r == '0) || (sample_index_r == end_idx)) ? 2'd0 :
                     (sample_index_r[0] ? 2'd2 : 2'd1);
  assign tw_en     = !len[0] && ((sample_index_r == end_idx) ||
                                 (sample_index_r == end_idx + 17'd1));
  assign last_item = (sample_index_r >= len - 17'd1);

  // Shared multiplier: the two sample products, then the two 32-bit halves of a magnitude.
  assign mult_m = (job_r == JOB_TERM) ? {8'd0, frequency_r} : spacing_r;

  always_comb begin
    case (state_r)
      S_RE1: begin
        mul_a = {{9{first_re_r[SAMPLE_W-1]}}, first_re_r};
        mul_b = {{9{second_re_r[SAMPLE_W-1]}}, second_re_r};
      end
      S_RE2: begin
        mul_a = {{9{first_im_r[SAMPLE_W-1]}}, first_im_r};
        mul_b = {{9{second_im_r[SAMPLE_W-1]}}, second_im_r};
      end
      S_MHI: begin
        mul_a = {1'b0, mag_r[63:32]};
        mul_b = {1'b0, mult_m};
      end
      default: begin
        mul_a = {1'b0, mag_r[31:0]};
        mul_b = {1'b0, mult_m};
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Shared divider, two steps per cycle.
  assign div_s0 = '{rem: div_rem_r, quo: div_quo_r};
  assign div_s1 = div_step(div_s0, div_den_r);
  assign div_s2 = div_step(div_s1, div_den_r);

  always_comb begin
    case (job_r)
      JOB_TERM: shifted = prod_r >> SHIFT_LOG;
      JOB_SIMP: shifted = prod_r >> SHIFT_SIMP;
      default:  shifted = prod_r >> SHIFT_TAIL;
    endcase
  end

  assign msat_mag    = sat_mag(shifted, neg_r);
  assign quo_sat     = sat_mag({30'd0, div_quo_r}, neg_r);
  assign re_abs      = re_r[48] ? 49'(-re_r) : re_r;
  assign wsh         = {2'd0, mag_r} << sw_shift;
  assign wsat        = sat_mag({30'd0, wsh}, neg_r);
  assign simpson_abs = simpson_r[63] ? 64'(-simpson_r) : simpson_r;
  assign tail_abs    = tail_r[63] ? 64'(-tail_r) : tail_r;
  assign out_load    = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt         = state_r;
    job_nxt           = job_r;
    div_cnt_nxt       = div_cnt_r;
    sample_count_nxt  = sample_count_r;
    spacing_nxt       = spacing_r;
    log_mode_nxt      = log_mode_r;
    sample_index_nxt  = sample_index_r;
    simpson_nxt       = simpson_r;
    tail_nxt          = tail_r;
    first_re_nxt      = first_re_r;
    first_im_nxt      = first_im_r;
    second_re_nxt     = second_re_r;
    second_im_nxt     = second_im_r;
    noise_power_nxt   = noise_power_r;
    frequency_nxt     = frequency_r;
    re_nxt            = re_r;
    prod_nxt          = prod_r;
    mag_nxt           = mag_r;
    neg_nxt           = neg_r;
    div_rem_nxt       = div_rem_r;
    div_quo_nxt       = div_quo_r;
    div_den_nxt       = div_den_r;
    s_nxt             = s_r;
    t_nxt             = t_r;
    wterm_nxt         = wterm_r;
    tterm_nxt         = tterm_r;
    res_nxt           = res_r;
    too_short_nxt     = too_short_r;
    out_integral_nxt  = out_integral_r;
    out_too_short_nxt = out_too_short_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count_nxt = cfg_wdata[COUNT_W-1:0];
        CFG_SPACING:      spacing_nxt      = cfg_wdata[SPACING_W-1:0];
        CFG_LOG_MODE:     log_mode_nxt     = cfg_wdata[0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          first_re_nxt    = in_tdata[SAMPLE_W-1:0];
          first_im_nxt    = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
          second_re_nxt   = in_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
          second_im_nxt   = in_tdata[4*SAMPLE_W-1:3*SAMPLE_W];
          noise_power_nxt = in_tdata[4*SAMPLE_W+NOISE_W-1:4*SAMPLE_W];
          frequency_nxt   = in_tdata[IN_TDATA_W-1:4*SAMPLE_W+NOISE_W];
          if (len == '0) begin
            // Zero length: answer at once, the integral state stays untouched.
            res_nxt       = '0;
            too_short_nxt = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            state_nxt = S_RE1;
          end
        end
      end
      S_RE1: begin
        re_nxt    = mul_p[48:0];
        state_nxt = S_RE2;
      end
      S_RE2: begin
        re_nxt    = re_r + mul_p[48:0];
        state_nxt = S_DLOAD;
      end
      S_DLOAD: begin
        // The real part carries 46 fraction bits; ten more give a 32-bit fraction quotient.
        neg_nxt     = re_r[48];
        div_rem_nxt = '0;
        div_quo_nxt = {8'd0, re_abs[47:0], 10'd0};
        div_den_nxt = (noise_power_r == '0) ? 32'd1 : noise_power_r;
        div_cnt_nxt = DIV_CNT_W'(DIV_CYCLES);
        job_nxt     = JOB_TERM;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        div_rem_nxt = div_s2.rem;
        div_quo_nxt = div_s2.quo;
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == DIV_CNT_W'(1)) begin
          state_nxt = S_DDONE;
        end
      end
      S_DDONE: begin
        case (job_r)
          JOB_TERM: begin
            mag_nxt   = div_quo_r[63:0];
            state_nxt = log_mode_r ? S_MLO : S_WEIGHT;
          end
          JOB_SIMP: begin
            s_nxt     = with_sign(neg_r, quo_sat);
            state_nxt = S_TPREP;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_MLO: begin
        prod_nxt  = {32'd0, mul_p[63:0]};
        state_nxt = S_MHI;
      end
      S_MHI: begin
        prod_nxt  = prod_r + {mul_p[63:0], 32'd0};
        state_nxt = S_MSAT;
      end
      S_MSAT: begin
        case (job_r)
          JOB_TERM: begin
            mag_nxt   = msat_mag;
            state_nxt = S_WEIGHT;
          end
          JOB_SIMP: begin
            // Four thirds of the scaled Simpson sum: divide four times the magnitude by three.
            div_rem_nxt = '0;
            div_quo_nxt = {msat_mag, 2'b00};
            div_den_nxt = DIV_THREE;
            div_cnt_nxt = DIV_CNT_W'(DIV_CYCLES);
            state_nxt   = S_DIV;
          end
          default: begin
            t_nxt     = with_sign(neg_r, msat_mag);
            state_nxt = S_FSUM;
          end
        endcase
      end
      S_WEIGHT: begin
        wterm_nxt = with_sign(neg_r, wsat);
        tterm_nxt = with_sign(neg_r, mag_r);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (sw_en) begin
          simpson_nxt = sat_add(simpson_r, wterm_r);
        end
        if (tw_en) begin
          tail_nxt = sat_add(tail_r, tterm_r);
        end
        if (last_item) begin
          state_nxt = S_SPREP;
        end else begin
          sample_index_nxt = sample_index_r + 17'd1;
          state_nxt        = S_IDLE;
        end
      end
      S_SPREP: begin
        neg_nxt   = simpson_r[63];
        mag_nxt   = simpson_abs;
        job_nxt   = JOB_SIMP;
        state_nxt = S_MLO;
      end
      S_TPREP: begin
        neg_nxt   = tail_r[63];
        mag_nxt   = tail_abs;
        job_nxt   = JOB_TAIL;
        state_nxt = S_MLO;
      end
      S_FSUM: begin
        res_nxt          = sat_add(s_r, t_r);
        too_short_nxt    = (len < 17'd3);
        sample_index_nxt = '0;
        simpson_nxt      = '0;
        tail_nxt         = '0;
        state_nxt        = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          out_integral_nxt  = res_r;
          out_too_short_nxt = too_short_r;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      job_r          <= JOB_TERM;
      div_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
      sample_count_r <= SAMPLE_COUNT_RESET;
      spacing_r      <= '0;
      log_mode_r     <= 1'b0;
      sample_index_r <= '0;
      simpson_r      <= '0;
      tail_r         <= '0;
    end else begin
      state_r        <= state_nxt;
      job_r          <= job_nxt;
      div_cnt_r      <= div_cnt_nxt;
      out_valid_r    <= out_valid_nxt;
      sample_count_r <= sample_count_nxt;
      spacing_r      <= spacing_nxt;
      log_mode_r     <= log_mode_nxt;
      sample_index_r <= sample_index_nxt;
      simpson_r      <= simpson_nxt;
      tail_r         <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_re_r      <= first_re_nxt;
    first_im_r      <= first_im_nxt;
    second_re_r     <= second_re_nxt;
    second_im_r     <= second_im_nxt;
    noise_power_r   <= noise_power_nxt;
    frequency_r     <= frequency_nxt;
    re_r            <= re_nxt;
    prod_r          <= prod_nxt;
    mag_r           <= mag_nxt;
    neg_r           <= neg_nxt;
    div_rem_r       <= div_rem_nxt;
    div_quo_r       <= div_quo_nxt;
    div_den_r       <= div_den_nxt;
    s_r             <= s_nxt;
    t_r             <= t_nxt;
    wterm_r         <= wterm_nxt;
    tterm_r         <= tterm_nxt;
    res_r           <= res_nxt;
    too_short_r     <= too_short_nxt;
    out_integral_r  <= out_integral_nxt;
    out_too_short_r <= out_too_short_nxt;
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Simpson weighted inner product, with a built-in predictor.

module tb;

  // Sample item as it travels on in_tdata; the packed layout puts first_re in the lowest
  // bits and frequency in the highest, so the struct can be driven onto the port as is.
  typedef struct packed {
    logic        [23:0] frequency;
    logic        [31:0] noise_power;
    logic signed [23:0] second_im;
    logic signed [23:0] second_re;
    logic signed [23:0] first_im;
    logic signed [23:0] first_re;
  } grid_sample_t;

  // One finished integral as it should appear on the result stream.
  typedef struct packed {
    logic [63:0] integral;
    logic        too_short;
  } integral_t;

  localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [23:0] Q23_MIN = 24'h80_0000;
  localparam logic [23:0] Q23_MAX = 24'h7F_FFFF;

  // Pause after draining, so that a sample that makes no result can finish.
  localparam int SETTLE_CYCLES  = 120;
  // Long receiver hold-off, long enough for the block to back up into its input.
  localparam int FREEZE_CYCLES  = 300;
  localparam int RANDOM_SAMPLES = 1610;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic [swip_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [swip_pkg::RESULT_W-1:0]   out_tdata;
  logic                            out_tuser;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [swip_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [swip_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  simpson_weighted_inner_product u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the registers, as last written.
  logic [swip_pkg::COUNT_W-1:0]   sh_count   = swip_pkg::SAMPLE_COUNT_RESET;
  logic [swip_pkg::SPACING_W-1:0] sh_spacing = '0;
  logic                           sh_log     = 1'b0;

  // Predicted integration state: position in the integral and the two running sums.
  logic [swip_pkg::COUNT_W-1:0] sample_pos  = '0;
  logic signed [63:0]           simpson_acc = '0;
  logic signed [63:0]           tail_acc    = '0;

  grid_sample_t sample_q[$];
  integral_t    integral_q[$];

  int queued_samples   = 0;
  int accepted_samples = 0;
  int integrals_seen   = 0;
  int fail_count       = 0;
  int phase_count      = 0;
  int send_idle_max    = 4;
  int recv_idle_max    = 4;
  int freeze_token     = 0;

  // ---------------------------------------------------------------------------------------
  // Fixed-point helpers for the predictor. Products and quotients are done on magnitudes with the sign
  // applied last, with truncation toward zero and saturation to signed 64 bits.
  // ---------------------------------------------------------------------------------------
  function automatic logic [63:0] magnitude(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [63:0] apply_sign(input logic neg, input logic [63:0] m);
    if (!neg) begin
      return m;
    end
    if (m[63]) begin
      return I64_MIN;
    end
    return -m;
  endfunction

  function automatic logic signed [63:0] add_clamp(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = a + b;
    if (s > I64_MAX) begin
      return I64_MAX;
    end
    if (s < I64_MIN) begin
      return I64_MIN;
    end
    return s[63:0];
  endfunction

  // (x * m) >> sh on the magnitude, clamped to what the sign of x can hold.
  function automatic logic signed [63:0] scale_shift(input logic signed [63:0] x,
                                                     input logic [31:0] m, input int sh);
    logic [63:0]  cap;
    logic [127:0] prod;
    cap  = x[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    prod = ({64'd0, magnitude(x)} * {96'd0, m}) >> sh;
    if (prod > {64'd0, cap}) begin
      prod = {64'd0, cap};
    end
    return apply_sign(x[63], prod[63:0]);
  endfunction

  // floor(4 * |x| / 3) with the sign of x, clamped.
  function automatic logic signed [63:0] times_four_thirds(input logic signed [63:0] x);
    logic [63:0]  cap;
    logic [127:0] prod;
    cap  = x[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    prod = ({64'd0, magnitude(x)} * 128'd4) / 128'd3;
    if (prod > {64'd0, cap}) begin
      prod = {64'd0, cap};
    end
    return apply_sign(x[63], prod[63:0]);
  endfunction

  // Advances the predicted state by one accepted sample and queues the integral it closes.
  task automatic integrate_sample(input grid_sample_t s);
    int unsigned        len;
    int unsigned        last_pt;
    int unsigned        weight;
    logic               tail_hit;
    logic [31:0]        divisor;
    logic [63:0]        quot;
    logic signed [63:0] cross_re;
    logic signed [63:0] term;
    logic signed [63:0] simp_part;
    logic signed [63:0] tail_part;
    integral_t          r;
    len = (sh_count > swip_pkg::MAX_SAMPLES) ? swip_pkg::MAX_SAMPLES : sh_count;
    if (len == 0) begin
      // A zero length answers every sample at once and leaves the sums alone.
      r.integral  = '0;
      r.too_short = 1'b1;
      integral_q  = {integral_q, r};
    end else begin
      // A zero noise power divides by one instead.
      divisor  = (s.noise_power == '0) ? 32'd1 : s.noise_power;
      cross_re = s.first_re * s.second_re + s.first_im * s.second_im;
      quot     = (magnitude(cross_re) << 10) / {32'd0, divisor};
      term     = apply_sign(cross_re < 0, quot);
      if (sh_log) begin
        term = scale_shift(term, {8'd0, s.frequency}, swip_pkg::SHIFT_LOG);
      end
      // Simpson runs over an odd number of points; an even length leaves the last
      // interval to the trapezoid.
      last_pt = (len % 2 == 0) ? len - 2 : len - 1;
      weight  = 0;
      if (last_pt != 0) begin
        if (sample_pos == 0 || sample_pos == last_pt) begin
          weight = 1;
        end else if (sample_pos < last_pt) begin
          weight = sample_pos[0] ? 4 : 2;
        end
      end
      tail_hit = (len % 2 == 0) && (sample_pos == last_pt || sample_pos == last_pt + 1);
      if (weight != 0) begin
        simpson_acc = add_clamp(simpson_acc, scale_shift(term, weight, 0));
      end
      if (tail_hit) begin
        tail_acc = add_clamp(tail_acc, term);
      end
      // Checked against the current length, so a shortened length ends the integral here.
      if (sample_pos >= len - 1) begin
        simp_part   = times_four_thirds(scale_shift(simpson_acc, sh_spacing,
                                                    swip_pkg::SHIFT_SIMP));
        tail_part   = scale_shift(tail_acc, sh_spacing, swip_pkg::SHIFT_TAIL);
        r.integral  = add_clamp(simp_part, tail_part);
        r.too_short = (len < 3);
        integral_q  = {integral_q, r};
        sample_pos  = '0;
        simpson_acc = '0;
        tail_acc    = '0;
      end else begin
        sample_pos = sample_pos + 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver: takes samples from sample_q, holds each until accepted, then waits its drawn
  // number of idle cycles. The prediction is made at the edge where a sample is accepted.
  // ---------------------------------------------------------------------------------------
  grid_sample_t on_wire;
  int           tx_gap = 0;

  always @(posedge clk) begin : sample_driver
    grid_sample_t next_sample;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        integrate_sample(on_wire);
        accepted_samples++;
      end
      if (in_tvalid && !in_tready) begin
        // Still offered; hold the item.
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        next_sample = sample_q.pop_front();
        on_wire     = next_sample;
        in_tdata  <= next_sample;
        in_tvalid <= 1'b1;
        tx_gap = $urandom_range(send_idle_max, 0);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: compares each accepted result with the oldest prediction, then stalls for its
  // drawn number of cycles. A new freeze token starts a long hold-off counted here.
  // ---------------------------------------------------------------------------------------
  int rx_hold     = 0;
  int freeze_left = 0;
  int freeze_seen = 0;

  always @(posedge clk) begin : integral_monitor
    integral_t want;
    logic      ready_next;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        integrals_seen++;
        if (integral_q.size() == 0) begin
          $error("unexpected result: integral %h too_short %b", out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = integral_q.pop_front();
          if (out_tdata !== want.integral) begin
            $error("integral: expected %h, actual %h", want.integral, out_tdata);
            fail_count++;
          end
          if (out_tuser !== want.too_short) begin
            $error("too_short: expected %b, actual %b", want.too_short, out_tuser);
            fail_count++;
          end
        end
        rx_hold = $urandom_range(recv_idle_max, 0);
      end
      if (freeze_seen != freeze_token) begin
        freeze_seen = freeze_token;
        freeze_left = FREEZE_CYCLES;
      end
      if (freeze_left > 0) begin
        freeze_left--;
        ready_next = 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_tready <= ready_next;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------
  task automatic cfg_write(input logic [swip_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      swip_pkg::CFG_SAMPLE_COUNT: sh_count   = value[swip_pkg::COUNT_W-1:0];
      swip_pkg::CFG_SPACING:      sh_spacing = value;
      swip_pkg::CFG_LOG_MODE:     sh_log     = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_sample(input grid_sample_t s);
    sample_q = {sample_q, s};
    queued_samples++;
  endtask

  // Waits until every queued sample has been taken and every predicted result has arrived.
  task automatic wait_drained();
    while (accepted_samples != queued_samples || integral_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Drains, then lets a sample that closes no integral finish before the next write.
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    phase_count++;
  endtask

  function automatic grid_sample_t make_sample(input logic [23:0] are, input logic [23:0] aim,
                                               input logic [23:0] bre, input logic [23:0] bim,
                                               input logic [31:0] np, input logic [23:0] f);
    grid_sample_t s;
    s.first_re    = are;
    s.first_im    = aim;
    s.second_re   = bre;
    s.second_im   = bim;
    s.noise_power = np;
    s.frequency   = f;
    return s;
  endfunction

  // Q1.23 value: mostly the full range, sometimes an extreme or a value near zero.
  function automatic logic [23:0] rand_q123();
    case ($urandom_range(7, 0))
      0: return Q23_MIN;
      1: return Q23_MAX;
      2: return 24'($urandom_range(64, 0) - 32);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic grid_sample_t rand_sample();
    grid_sample_t s;
    s.first_re  = rand_q123();
    s.first_im  = rand_q123();
    s.second_re = rand_q123();
    s.second_im = rand_q123();
    // Small noise powers give large terms, so saturation shows up now and then.
    case ($urandom_range(9, 0))
      0: s.noise_power = '0;
      1: s.noise_power = 32'hFFFF_FFFF;
      2, 3, 4: s.noise_power = $urandom_range(32'h0400_0000, 1);
      default: s.noise_power = $urandom;
    endcase
    s.frequency = $urandom_range(1, 0) ? 24'($urandom) : 24'($urandom_range(32'h1000, 0));
    return s;
  endfunction

  // Mostly short integrals; now and then a zero, a too-short or an over-the-cap length.
  function automatic logic [31:0] pick_length();
    case ($urandom_range(19, 0))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd2;
      3: return 32'(swip_pkg::MAX_SAMPLES) + $urandom_range(65535, 0);
      4: return 32'(swip_pkg::MAX_SAMPLES);
      5, 6: return $urandom_range(64, 13);
      7: return ($urandom_range(3, 0) == 0) ? $urandom_range(130, 65) : 32'd3;
      default: return $urandom_range(12, 3);
    endcase
  endfunction

  function automatic logic [31:0] pick_spacing();
    case ($urandom_range(7, 0))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom_range(32'h0200_0000, 0);
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Test sequence: directed cases, two pressure phases, then random phases. Registers are
  // only written after settle(), so the block is idle at every write.
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned cur_len;
    int unsigned n;
    int          random_samples;
    bit          split;
    random_samples = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults: length three, zero spacing, linear mode. Largest positive cross
    // product over the smallest divisor, a zero noise power, and the largest divisor.
    queue_sample(make_sample(Q23_MIN, Q23_MIN, Q23_MIN, Q23_MIN, 32'd1, 24'hFF_FFFF));
    queue_sample(make_sample(Q23_MAX, Q23_MAX, Q23_MIN, Q23_MIN, 32'd0, 24'h00_0000));
    queue_sample(make_sample(Q23_MAX, Q23_MIN, Q23_MAX, Q23_MIN, 32'hFFFF_FFFF, 24'h80_0000));
    settle();

    // Largest spacing in log mode: the extreme terms saturate through every stage.
    cfg_write(swip_pkg::CFG_SPACING, 32'hFFFF_FFFF);
    cfg_write(swip_pkg::CFG_LOG_MODE, 32'd1);
    queue_sample(make_sample(Q23_MIN, Q23_MIN, Q23_MIN, Q23_MIN, 32'd1, 24'hFF_FFFF));
    queue_sample(make_sample(Q23_MAX, Q23_MAX, Q23_MIN, Q23_MIN, 32'd1, 24'hFF_FFFF));
    queue_sample(make_sample(24'd1, 24'd0, 24'd1, 24'd0, 32'd1, 24'd0));
    settle();

    // Zero length: every sample is answered at once.
    cfg_write(swip_pkg::CFG_SAMPLE_COUNT, 32'd0);
    queue_sample(rand_sample());
    queue_sample(rand_sample());
    settle();

    // Length one gives zero; length two is a plain trapezoid; both flag too_short.
    cfg_write(swip_pkg::CFG_SAMPLE_COUNT, 32'd1);
    cfg_write(swip_pkg::CFG_SPACING, 32'h0100_0000);
    cfg_write(swip_pkg::CFG_LOG_MODE, 32'd0);
    queue_sample(rand_sample());
    queue_sample(rand_sample());
    settle();
    cfg_write(swip_pkg::CFG_SAMPLE_COUNT, 32'd2);
    queue_sample(rand_sample());
    queue_sample(rand_sample());
    settle();

    // Even length with Simpson plus the trailing trapezoid, in log mode.
    cfg_write(swip_pkg::CFG_SAMPLE_COUNT, 32'd4);
    cfg_write(swip_pkg::CFG_LOG_MODE, 32'd1);
    repeat (4) queue_sample(rand_sample());
    settle();

    // Lengths above the cap, then the cap itself, then a shortened length that closes the
    // open integral on the next sample.
    cfg_write(swip_pkg::CFG_SAMPLE_COUNT, 32'h1_FFFF);
    repeat (3) queue_sample(rand_sample());
    settle();
    cfg_write(swip_pkg::CFG_SAMPLE_COUNT, 32'(swip_pkg::MAX_SAMPLES));
    repeat (2) queue_sample(rand_sample());
    settle();
    cfg_write(swip_pkg::CFG_SAMPLE_COUNT, 32'd2);
    queue_sample(rand_sample());
    settle();

    // Receiver holds off while the sender keeps going: one result fills the output
    // register, the next stalls the sequencer and in_tready drops.
    cfg_write(swip_pkg::CFG_SAMPLE_COUNT, 32'd1);
    send_idle_max = 0;
    freeze_token++;
    repeat (16) queue_sample(rand_sample());
    settle();

    // Sender stops mid-integral until everything is back, then finishes the integral.
    cfg_write(swip_pkg::CFG_SAMPLE_COUNT, 32'd10);
    send_idle_max = 4;
    repeat (5) queue_sample(rand_sample());
    wait_drained();
    repeat (5) queue_sample(rand_sample());
    settle();

    while (random_samples < RANDOM_SAMPLES) begin
      // A third of the phases run with no idling on that side.
      send_idle_max = ($urandom_range(2, 0) == 0) ? 0 : 4;
      recv_idle_max = ($urandom_range(2, 0) == 0) ? 0 : 4;
      if ($urandom_range(3, 0) != 0) begin
        cfg_write(swip_pkg::CFG_SAMPLE_COUNT, pick_length());
      end
      if ($urandom_range(1, 0) != 0) begin
        cfg_write(swip_pkg::CFG_SPACING, pick_spacing());
      end
      if ($urandom_range(1, 0) != 0) begin
        cfg_write(swip_pkg::CFG_LOG_MODE, $urandom_range(1, 0));
      end
      cur_len = (sh_count > swip_pkg::MAX_SAMPLES) ? swip_pkg::MAX_SAMPLES : sh_count;
      // Most phases send whole integrals; the rest leave one open, so the next phase
      // changes the length in the middle of an integral.
      if (cur_len == 0) begin
        n = $urandom_range(6, 1);
      end else if (cur_len > 130 || $urandom_range(3, 0) == 0) begin
        n = $urandom_range(8, 1);
      end else begin
        n = cur_len * $urandom_range((cur_len > 16) ? 1 : 3, 1);
      end
      split = ($urandom_range(7, 0) == 0);
      for (int k = 0; k < n; k++) begin
        if (split && k == n / 2) begin
          wait_drained();
        end
        queue_sample(rand_sample());
      end
      random_samples += n;
      settle();
    end

    $display("Run covered %0d samples and %0d integrals over %0d register phases,",
             accepted_samples, integrals_seen, phase_count);
    $display("with lengths from zero to above the cap, extreme spacings and both modes.");
    if (fail_count == 0 && integral_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung handshake; a correct run ends well before this.
  initial begin : watchdog
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
